FILE: src/dsmp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsmp_pkg: shared types and constants for the service-mode programmer
// Request/result structs, command and phase codes, packet builder functions.
// ----------------------------------------------------------------------------
package dsmp_pkg;

  localparam int AdcBits    = 12;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = 2;
  localparam int FifoCntW   = 3;

  // DCC instruction bytes
  localparam logic [7:0] InstrVerifyByte = 8'h74;
  localparam logic [7:0] InstrBitManip   = 8'h78;
  localparam logic [7:0] InstrWriteByte  = 8'h7C;
  localparam logic [7:0] BitVerifyBase   = 8'hE0;
  localparam logic [7:0] BitWriteBase    = 8'hF0;
  localparam logic [7:0] BitValueMask    = 8'h08;

  typedef enum logic [1:0] {
    CmdStart   = 2'd0,
    CmdSample  = 2'd1,
    CmdPktDone = 2'd2,
    CmdUnused  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KindPacket   = 2'd0,
    KindProgress = 2'd1,
    KindDone     = 2'd2,
    KindPowerOn  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CfgOpMode       = 3'd0,
    CfgWriteNotRead = 3'd1,
    CfgCvNumber     = 3'd2,
    CfgCvValue      = 3'd3,
    CfgBitPosition  = 3'd4,
    CfgBitValue     = 3'd5,
    CfgAckThreshold = 3'd6
  } cfg_idx_e;

  localparam logic [1:0] ModeDirectBit  = 2'd1;
  localparam logic [1:0] ModeDirectByte = 2'd2;

  typedef enum logic [3:0] {
    PhIdle     = 4'd0,
    PhBrInit   = 4'd1,
    PhBrGap    = 4'd2,
    PhBrVerify = 4'd3,
    PhYrInit   = 4'd4,
    PhYrFirst  = 4'd5,
    PhYrGap    = 4'd6,
    PhYrVerify = 4'd7,
    PhBwInit   = 4'd8,
    PhBwWrite  = 4'd9,
    PhBwPost   = 4'd10,
    PhYwInit   = 4'd11,
    PhYwWrite  = 4'd12,
    PhYwPost   = 4'd13
  } phase_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [AdcBits-1:0] current_sample;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pkt_byte0;
    logic [7:0] pkt_byte1;
    logic [7:0] pkt_byte2;
    logic [7:0] pkt_byte3;
    logic [2:0] pkt_length;
    logic [2:0] pkt_repeat;
    logic [7:0] progress_now;
    logic [7:0] progress_total;
    logic [7:0] cv_result;
    logic       ok;
    logic       last;
  } res_t;

  function automatic res_t res_blank(input kind_e kind);
    res_t r;
    r      = '0;
    r.kind = kind;
    return r;
  endfunction

  function automatic res_t res_reset_pkt();
    res_t r;
    r            = res_blank(KindPacket);
    r.pkt_length = 3'd3;
    r.pkt_repeat = 3'd3;
    return r;
  endfunction

  function automatic res_t res_pkt4(input logic [7:0] base, input logic [10:0] cv_num,
                                    input logic [7:0] b2, input logic [2:0] rep);
    res_t        r;
    logic [10:0] cv;
    cv           = cv_num - 11'd1;
    r            = res_blank(KindPacket);
    r.pkt_byte0  = base | {6'b0, cv[9:8]};
    r.pkt_byte1  = cv[7:0];
    r.pkt_byte2  = b2;
    r.pkt_byte3  = r.pkt_byte0 ^ r.pkt_byte1 ^ b2;
    r.pkt_length = 3'd4;
    r.pkt_repeat = rep;
    return r;
  endfunction

  function automatic res_t res_progress(input logic [7:0] now, input logic [7:0] total);
    res_t r;
    r                = res_blank(KindProgress);
    r.progress_now   = now;
    r.progress_total = total;
    return r;
  endfunction

  function automatic res_t res_done(input logic [7:0] value, input logic ok);
    res_t r;
    r           = res_blank(KindDone);
    r.cv_result = ok ? value : 8'd0;
    r.ok        = ok;
    return r;
  endfunction

endpackage : dsmp_pkg
`default_nettype wire

FILE: src/dcc_service_mode_programmer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcc_service_mode_programmer: DCC direct-mode CV read/write sequencer
// Issues reset, verify and write packet requests and detects decoder acks.
// ----------------------------------------------------------------------------
// Usage:
//   in_req_i carries a start, a current sample or a packet-done notice; the
//   request is taken when in_valid_i is high and in_stall_o is low.
//   out_res_o carries packet requests, progress, power-on and done results;
//   one is taken per cycle when out_valid_o is high and out_stall_i is low.
//   The cfg port (always ready) loads op mode, CV number, values and the ack
//   threshold; write it only while no operation is running.
// Timing:
//   A request lands in an input register and is decoded by one pass of
//   the phase logic once the queue has room for two results; its zero,
//   one or two results are written into a four-entry result queue, and
//   out_res_o shows the oldest. One request per cycle is taken while the queue
//   has two free slots; the queue drains one result per cycle, so a long
//   stall on the result side fills it and then raises in_stall_o.
// Reset:
//   Phase goes idle, counters, baseline and ack state clear, the queue
//   empties and registers return to their documented defaults.
// ----------------------------------------------------------------------------
module dcc_service_mode_programmer
  import dsmp_pkg::*;
#(
  parameter int RESET_PACKETS = 6,
  parameter int BIT_ATTEMPTS  = 3
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire req_t        in_req_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output res_t             out_res_o,
  // configuration channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);

  localparam int CntLog = $clog2(RESET_PACKETS + 1);
  localparam int CntW   = (CntLog > 3) ? CntLog : 3;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0]         op_mode_q;
  logic               write_not_read_q;
  logic [10:0]        cv_number_q;
  logic [7:0]         cv_value_q;
  logic [2:0]         bit_position_q;
  logic               bit_value_q;
  logic [AdcBits-1:0] ack_threshold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q        <= 2'd0;
      write_not_read_q <= 1'b0;
      cv_number_q      <= 11'd1;
      cv_value_q       <= 8'd0;
      bit_position_q   <= 3'd0;
      bit_value_q      <= 1'b0;
      ack_threshold_q  <= AdcBits'(5);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgOpMode:       op_mode_q        <= cfg_data_i[1:0];
        CfgWriteNotRead: write_not_read_q <= cfg_data_i[0];
        CfgCvNumber:     cv_number_q      <= cfg_data_i[10:0];
        CfgCvValue:      cv_value_q       <= cfg_data_i[7:0];
        CfgBitPosition:  bit_position_q   <= cfg_data_i[2:0];
        CfgBitValue:     bit_value_q      <= cfg_data_i[0];
        CfgAckThreshold: ack_threshold_q  <= cfg_data_i[AdcBits-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic               s1_valid_q;
  req_t               s1_req_q;
  logic               proceed;
  logic               in_accept;
  logic [FifoCntW-1:0] fifo_cnt_q;

  // decode only when the queue can absorb the worst case of two results
  assign proceed    = s1_valid_q && (fifo_cnt_q <= FifoCntW'(FifoDepth - 2));
  assign in_stall_o = s1_valid_q && !proceed;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (proceed) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_req_q <= in_req_i;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  phase_e             phase_q, phase_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [2:0]         bit_idx_q, bit_idx_d;
  logic [1:0]         attempt_q, attempt_d;
  logic [7:0]         trial_q, trial_d;
  logic [7:0]         asm_q, asm_d;
  logic [AdcBits-1:0] baseline_q, baseline_d;
  logic [AdcBits-1:0] latest_q, latest_d;
  logic               ack_q, ack_d;
  logic               armed_q, armed_d;

  res_t       res0, res1;
  logic [1:0] nres;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      cnt_q      <= '0;
      bit_idx_q  <= 3'd0;
      attempt_q  <= 2'd0;
      trial_q    <= 8'd0;
      asm_q      <= 8'd0;
      baseline_q <= '0;
      latest_q   <= '0;
      ack_q      <= 1'b0;
      armed_q    <= 1'b0;
    end else if (proceed) begin
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      bit_idx_q  <= bit_idx_d;
      attempt_q  <= attempt_d;
      trial_q    <= trial_d;
      asm_q      <= asm_d;
      baseline_q <= baseline_d;
      latest_q   <= latest_d;
      ack_q      <= ack_d;
      armed_q    <= armed_d;
    end
  end

  logic [7:0] bit_verify_b2;
  logic [7:0] bit_write_b2;
  logic [7:0] asm_next;

  assign bit_verify_b2 = BitVerifyBase | {5'b0, bit_idx_q}
                         | ((trial_q != 8'd0) ? BitValueMask : 8'd0);
  assign bit_write_b2  = BitWriteBase | {5'b0, bit_position_q}
                         | (bit_value_q ? BitValueMask : 8'd0);
  assign asm_next      = (trial_q != 8'd0) ? (asm_q | (8'd1 << bit_idx_q)) : asm_q;

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    bit_idx_d  = bit_idx_q;
    attempt_d  = attempt_q;
    trial_d    = trial_q;
    asm_d      = asm_q;
    baseline_d = baseline_q;
    latest_d   = latest_q;
    ack_d      = ack_q;
    armed_d    = armed_q;
    res0       = '0;
    res1       = '0;
    nres       = 2'd0;

    case (cmd_e'(s1_req_q.cmd))
      CmdStart: begin
        // a start while busy, or in paged/unknown mode, is dropped
        if (phase_q == PhIdle &&
            (op_mode_q == ModeDirectBit || op_mode_q == ModeDirectByte)) begin
          if (op_mode_q == ModeDirectBit) begin
            phase_d = write_not_read_q ? PhBwInit : PhBrInit;
          end else begin
            phase_d = write_not_read_q ? PhYwInit : PhYrInit;
          end
          armed_d = 1'b0;
          ack_d   = 1'b0;
          cnt_d   = CntW'(1);
          res0    = res_blank(KindPowerOn);
          res1    = res_reset_pkt();
          nres    = 2'd2;
        end
      end

      CmdSample: begin
        latest_d = s1_req_q.current_sample;
        if (armed_q && s1_req_q.current_sample > baseline_q &&
            (s1_req_q.current_sample - baseline_q) > ack_threshold_q) begin
          ack_d = 1'b1;
        end
      end

      CmdPktDone: begin
        nres = 2'd1;
        case (phase_q)
          PhBrInit, PhYrInit, PhBwInit, PhYwInit: begin
            if (cnt_q < CntW'(RESET_PACKETS)) begin
              cnt_d = cnt_q + CntW'(1);
              res0  = res_reset_pkt();
            end else begin
              // power-up resets finished: latch the quiescent current
              baseline_d = latest_q;
              armed_d    = 1'b1;
              ack_d      = 1'b0;
              cnt_d      = CntW'(1);
              case (phase_q)
                PhBrInit: begin
                  bit_idx_d = 3'd0;
                  attempt_d = 2'd0;
                  trial_d   = 8'd0;
                  asm_d     = 8'd0;
                  phase_d   = PhBrGap;
                  res0      = res_progress(8'd1, 8'd8);
                  res1      = res_reset_pkt();
                  nres      = 2'd2;
                end
                PhYrInit: begin
                  phase_d = PhYrFirst;
                  trial_d = 8'hFF;
                  res0    = res_pkt4(InstrVerifyByte, cv_number_q, 8'hFF, 3'd1);
                end
                PhBwInit: begin
                  phase_d = PhBwWrite;
                  res0    = res_pkt4(InstrBitManip, cv_number_q, bit_write_b2, 3'd1);
                end
                default: begin
                  phase_d = PhYwWrite;
                  res0    = res_pkt4(InstrWriteByte, cv_number_q, cv_value_q, 3'd6);
                end
              endcase
            end
          end

          PhBrGap, PhYrGap: begin
            if (cnt_q < CntW'(2)) begin
              cnt_d = cnt_q + CntW'(1);
              res0  = res_reset_pkt();
            end else begin
              ack_d = 1'b0;
              cnt_d = CntW'(1);
              if (phase_q == PhBrGap) begin
                phase_d = PhBrVerify;
                res0    = res_pkt4(InstrBitManip, cv_number_q, bit_verify_b2, 3'd1);
              end else begin
                phase_d = PhYrVerify;
                res0    = res_pkt4(InstrVerifyByte, cv_number_q, trial_q, 3'd1);
              end
            end
          end

          PhBrVerify: begin
            if (cnt_q < CntW'(2)) begin
              cnt_d = CntW'(2);
              res0  = res_pkt4(InstrBitManip, cv_number_q, bit_verify_b2, 3'd5);
            end else if (ack_q) begin
              asm_d = asm_next;
              if (bit_idx_q == 3'd7) begin
                phase_d = PhIdle;
                armed_d = 1'b0;
                cnt_d   = '0;
                res0    = res_done(asm_next, 1'b1);
              end else begin
                bit_idx_d = bit_idx_q + 3'd1;
                attempt_d = 2'd0;
                trial_d   = 8'd0;
                phase_d   = PhBrGap;
                cnt_d     = CntW'(1);
                res0      = res_progress({5'b0, bit_idx_q} + 8'd2, 8'd8);
                res1      = res_reset_pkt();
                nres      = 2'd2;
              end
            end else if (trial_q == 8'd0) begin
              // no ack on zero: try one
              trial_d = 8'd1;
              phase_d = PhBrGap;
              cnt_d   = CntW'(1);
              res0    = res_reset_pkt();
            end else begin
              attempt_d = attempt_q + 2'd1;
              if (({1'b0, attempt_q} + 3'd1) >= 3'(BIT_ATTEMPTS)) begin
                phase_d = PhIdle;
                armed_d = 1'b0;
                cnt_d   = '0;
                res0    = res_done(8'd0, 1'b0);
              end else begin
                trial_d = 8'd0;
                phase_d = PhBrGap;
                cnt_d   = CntW'(1);
                res0    = res_progress({5'b0, bit_idx_q} + 8'd1, 8'd8);
                res1    = res_reset_pkt();
                nres    = 2'd2;
              end
            end
          end

          PhYrFirst, PhYrVerify: begin
            if (cnt_q < CntW'(6)) begin
              cnt_d = cnt_q + CntW'(1);
              res0  = res_pkt4(InstrVerifyByte, cv_number_q, trial_q, 3'd1);
            end else if (ack_q) begin
              phase_d = PhIdle;
              armed_d = 1'b0;
              cnt_d   = '0;
              res0    = res_done(trial_q, 1'b1);
            end else if (phase_q == PhYrVerify && trial_q >= 8'd254) begin
              phase_d = PhIdle;
              armed_d = 1'b0;
              cnt_d   = '0;
              res0    = res_done(8'd0, 1'b0);
            end else begin
              // advance the trial value: 255 first, then 0 upward
              trial_d = (phase_q == PhYrFirst) ? 8'd0 : trial_q + 8'd1;
              phase_d = PhYrGap;
              cnt_d   = CntW'(1);
              res0    = res_progress(trial_d, 8'd255);
              res1    = res_reset_pkt();
              nres    = 2'd2;
            end
          end

          PhBwWrite: begin
            if (cnt_q < CntW'(2)) begin
              cnt_d = CntW'(2);
              res0  = res_pkt4(InstrBitManip, cv_number_q, bit_write_b2, 3'd5);
            end else begin
              phase_d = PhBwPost;
              cnt_d   = CntW'(1);
              res0    = res_reset_pkt();
            end
          end

          PhYwWrite: begin
            phase_d = PhYwPost;
            cnt_d   = CntW'(1);
            res0    = res_reset_pkt();
          end

          PhBwPost, PhYwPost: begin
            if (cnt_q < CntW'(RESET_PACKETS)) begin
              cnt_d = cnt_q + CntW'(1);
              res0  = res_reset_pkt();
            end else begin
              phase_d = PhIdle;
              armed_d = 1'b0;
              cnt_d   = '0;
              res0    = res_done(8'd0, ack_q);
            end
          end

          default: begin
            // packet done while idle: drop
            phase_d = PhIdle;
            nres    = 2'd0;
          end
        endcase
      end

      default: ;
    endcase

    // mark the final result of this request
    if (nres == 2'd1) begin
      res0.last = 1'b1;
    end else if (nres == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  res_t                fifo_mem [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic                pop;
  logic [1:0]          npush;

  assign npush       = proceed ? nres : 2'd0;
  assign out_valid_o = (fifo_cnt_q != '0);
  assign out_res_o   = fifo_mem[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) begin
      fifo_mem[wr_ptr_q] <= res0;
    end
    if (npush == 2'd2) begin
      fifo_mem[wr_ptr_q + FifoPtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_q + FifoPtrW'(npush);
      rd_ptr_q   <= rd_ptr_q + FifoPtrW'(pop);
      fifo_cnt_q <= fifo_cnt_q + FifoCntW'(npush) - FifoCntW'(pop);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= FifoCntW'(FifoDepth))
    else $error("result queue overflow");

  a_armed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> phase_q != PhIdle)
    else $error("ack sampling armed while idle");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    npush != 2'd0 |-> fifo_cnt_q <= FifoCntW'(FifoDepth - 2))
    else $error("results pushed without room");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.kind == KindDone) |-> out_res_o.last)
    else $error("done result not marked last");

  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (npush != 2'd0 && res0.kind == KindDone) |=> phase_q == PhIdle)
    else $error("sequencer busy after done");

endmodule : dcc_service_mode_programmer
`default_nettype wire
